// ===== rtl/core/skb_pkg.sv =====
package skb_pkg;

   localparam int SAMPLE_WIDTH        = 16;
   localparam int NUM_SENSORS_DEFAULT = 8;
   localparam int INDEX_WIDTH         = 3;
   localparam int CSR_INDEX_WIDTH     = 3;
   localparam int CSR_DATA_WIDTH      = 32;
   localparam int MAG_WIDTH           = 62;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PREDICT_FACTOR   = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MEASURE_FACTOR   = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PROCESS_NOISE    = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SENSOR_NOISE     = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_START_COVARIANCE = 3'd4;

   localparam logic [31:0]          ONE_Q = 32'h0001_0000;
   localparam logic [MAG_WIDTH-1:0] CAP   = '1;

   localparam logic [2:0] STEP_AA  = 3'd0;
   localparam logic [2:0] STEP_PU  = 3'd1;
   localparam logic [2:0] STEP_HP  = 3'd2;
   localparam logic [2:0] STEP_DEN = 3'd3;
   localparam logic [2:0] STEP_HX  = 3'd4;
   localparam logic [2:0] STEP_KI  = 3'd5;
   localparam logic [2:0] STEP_KH  = 3'd6;
   localparam logic [2:0] STEP_PN  = 3'd7;

   typedef struct packed {
      logic                           cmd;
      logic [INDEX_WIDTH-1:0]         sensor_index;
      logic signed [SAMPLE_WIDTH-1:0] sample_value;
   } req_type;

   typedef struct packed {
      logic [INDEX_WIDTH-1:0]         channel;
      logic signed [SAMPLE_WIDTH-1:0] estimate;
      logic [31:0]                    covariance_out;
      logic                           degenerate;
      logic                           clipped;
   } rsp_type;

   typedef struct packed {
      logic       capture_item;
      logic       read_bank;
      logic       calc_xp;
      logic       mul_start;
      logic       mul_capture;
      logic       div_start;
      logic       div_capture;
      logic       write_bank;
      logic       load_rsp;
      logic [2:0] step;
   } ctrl_cmd_type;

   typedef struct packed {
      logic item_load;
      logic item_oor;
      logic mul_done;
      logic div_done;
   } ctrl_sts_type;

endpackage

// ===== rtl/core/skb_mul.sv =====
module skb_mul (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [skb_pkg::MAG_WIDTH-1:0]   op_a,
   input  logic [skb_pkg::MAG_WIDTH-1:0]   op_b,
   output logic                            done,
   output logic [skb_pkg::MAG_WIDTH-1:0]   result
);

   localparam int MW = skb_pkg::MAG_WIDTH;
   localparam int HW = MW / 2;

   logic [MW-1:0]   a_ff, b_ff, prod_ff, part;
   logic [2*MW-1:0] acc_ff, shifted;
   logic [2:0]      cnt_ff;
   logic            busy_ff, done_ff;
   logic [1:0]      pidx, lidx;
   logic [HW-1:0]   a_half, b_half;

   assign pidx   = cnt_ff[1:0];
   assign lidx   = cnt_ff[1:0] - 2'd1;
   assign a_half = pidx[1] ? a_ff[MW-1:HW] : a_ff[HW-1:0];
   assign b_half = pidx[0] ? b_ff[MW-1:HW] : b_ff[HW-1:0];
   assign part   = MW'(a_half) * MW'(b_half);

   always_comb begin
      unique case (lidx)
         2'd0:    shifted = {{MW{1'b0}}, prod_ff};
         2'd3:    shifted = {prod_ff, {MW{1'b0}}};
         default: shifted = {{HW{1'b0}}, prod_ff, {HW{1'b0}}};
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 3'd1;
            if (cnt_ff == 3'd4) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         a_ff   <= op_a;
         b_ff   <= op_b;
         acc_ff <= '0;
      end else if (busy_ff) begin
         if (cnt_ff != 3'd4) begin
            prod_ff <= part;
         end
         if (cnt_ff != 3'd0) begin
            acc_ff <= acc_ff + shifted;
         end
      end
   end

   assign done   = done_ff;
   assign result = (|acc_ff[2*MW-1:64]) ? skb_pkg::CAP : MW'(acc_ff[63:16]);

endmodule

// ===== rtl/core/skb_div.sv =====
module skb_div (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [skb_pkg::MAG_WIDTH:0]     num,
   input  logic [skb_pkg::MAG_WIDTH-1:0]   den,
   output logic                            done,
   output logic [skb_pkg::MAG_WIDTH:0]     quot
);

   localparam int MW = skb_pkg::MAG_WIDTH;

   logic [MW-1:0] rem_ff, den_ff;
   logic [MW:0]   quo_ff, trial, diff;
   logic [5:0]    cnt_ff;
   logic          busy_ff, done_ff, ge;

   assign trial = {rem_ff, quo_ff[MW]};
   assign diff  = trial - {1'b0, den_ff};
   assign ge    = trial >= {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 6'd1;
            if (cnt_ff == 6'(MW)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         quo_ff <= num;
         den_ff <= den;
      end else if (busy_ff) begin
         rem_ff <= ge ? diff[MW-1:0] : trial[MW-1:0];
         quo_ff <= {quo_ff[MW-1:0], ge};
      end
   end

   assign done = done_ff;
   assign quot = quo_ff;

endmodule

// ===== rtl/core/skb_datapath.sv =====
module skb_datapath #(
   parameter int NUM_SENSORS = skb_pkg::NUM_SENSORS_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  skb_pkg::req_type                      req_data,
   input  logic                                  csr_write,
   input  logic [skb_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [skb_pkg::CSR_DATA_WIDTH-1:0]    csr_wdata,
   input  skb_pkg::ctrl_cmd_type                 cmd,
   output skb_pkg::ctrl_sts_type                 sts,
   output skb_pkg::rsp_type                      rsp_data
);

   localparam int IDXW = (NUM_SENSORS > 1) ? $clog2(NUM_SENSORS) : 1;
   localparam int SW   = skb_pkg::SAMPLE_WIDTH;
   localparam int MW   = skb_pkg::MAG_WIDTH;
   localparam logic [6:0] NUM_S7 = 7'(NUM_SENSORS);
   localparam logic signed [63:0] CAP_S  = {2'b00, skb_pkg::CAP};
   localparam logic signed [63:0] ONE_S  = 64'(skb_pkg::ONE_Q);
   localparam logic signed [63:0] SMAX   = (64'sd1 <<< (SW - 1)) - 64'sd1;
   localparam logic signed [63:0] SMIN   = -SMAX - 64'sd1;

   function automatic logic [MW-1:0] mag62(input logic signed [63:0] v);
      logic [63:0] t;
      t = v[63] ? 64'(-v) : 64'(v);
      return t[MW-1:0];
   endfunction

   function automatic logic signed [63:0] apply_sign(input logic [MW-1:0] m, input logic neg);
      logic signed [63:0] t;
      t = $signed({2'b00, m});
      return neg ? -t : t;
   endfunction

   function automatic logic signed [63:0] clamp_cap(input logic signed [63:0] v);
      if (v > CAP_S) return CAP_S;
      if (v < -CAP_S) return -CAP_S;
      return v;
   endfunction

   logic signed [31:0]    predict_ff, measure_ff;
   logic [30:0]           pnoise_ff, snoise_ff, startcov_ff;
   skb_pkg::req_type      item_ff;
   logic                  oor_ff, oor_in;
   logic [IDXW+2:0]       idx_wide;
   logic [IDXW-1:0]       idx;

   logic signed [SW-1:0]  est_mem [NUM_SENSORS];
   logic [31:0]           cov_mem [NUM_SENSORS];
   logic [NUM_SENSORS-1:0] valid_ff;

   logic signed [SW-1:0]  x_ff, est_ff, est_in, res_est_ff;
   logic [31:0]           p_ff, pp_ff, pp_in, pn_ff, pn_in, res_cov_ff;
   logic signed [47:0]    xp_ff, xp_in;
   logic [MW-1:0]         aa_ff, hp_mag_ff, den_ff, den_in, km;
   logic                  hp_neg_ff, degen_ff, clip_ff, clip_in, res_degen_ff, res_clip_ff;
   logic signed [63:0]    innov_ff, innov_in, k_ff, om_ff, om_in, xq, est_full, z_q, sres;
   logic [63:0]           xq_mag, sum_pu, sum_den;
   skb_pkg::rsp_type      rsp_ff;

   logic [MW-1:0]         op_a, op_b, mres, mag_a, mag_h;
   logic                  op_neg, mul_done, div_done, den_zero;
   logic [MW:0]           quot;

   assign idx_wide = {{IDXW{1'b0}}, item_ff.sensor_index};
   assign idx      = idx_wide[IDXW-1:0];
   assign oor_in   = {4'b0, req_data.sensor_index} >= NUM_S7;

   always_ff @(posedge clock) begin
      if (reset) begin
         predict_ff  <= $signed(skb_pkg::ONE_Q);
         measure_ff  <= $signed(skb_pkg::ONE_Q);
         pnoise_ff   <= skb_pkg::ONE_Q[30:0];
         snoise_ff   <= skb_pkg::ONE_Q[30:0];
         startcov_ff <= skb_pkg::ONE_Q[30:0];
      end else if (csr_write) begin
         unique case (csr_index)
            skb_pkg::CSR_PREDICT_FACTOR:   predict_ff  <= $signed(csr_wdata);
            skb_pkg::CSR_MEASURE_FACTOR:   measure_ff  <= $signed(csr_wdata);
            skb_pkg::CSR_PROCESS_NOISE:    pnoise_ff   <= csr_wdata[30:0];
            skb_pkg::CSR_SENSOR_NOISE:     snoise_ff   <= csr_wdata[30:0];
            skb_pkg::CSR_START_COVARIANCE: startcov_ff <= csr_wdata[30:0];
            default: ;
         endcase
      end
   end

   assign mag_a = mag62(64'(predict_ff));
   assign mag_h = mag62(64'(measure_ff));

   always_comb begin
      op_a   = mag_h;
      op_b   = mag_h;
      op_neg = 1'b0;
      unique case (cmd.step)
         skb_pkg::STEP_AA: begin
            op_a = mag_a;
            op_b = mag_a;
         end
         skb_pkg::STEP_PU: begin
            op_a = aa_ff;
            op_b = MW'(p_ff);
         end
         skb_pkg::STEP_HP: begin
            op_b   = MW'(pp_ff);
            op_neg = measure_ff[31];
         end
         skb_pkg::STEP_DEN: begin
            op_a = hp_mag_ff;
         end
         skb_pkg::STEP_HX: begin
            op_b   = mag62(64'(xp_ff));
            op_neg = measure_ff[31] ^ xp_ff[47];
         end
         skb_pkg::STEP_KI: begin
            op_a   = mag62(k_ff);
            op_b   = mag62(innov_ff);
            op_neg = k_ff[63] ^ innov_ff[63];
         end
         skb_pkg::STEP_KH: begin
            op_a   = mag62(k_ff);
            op_neg = k_ff[63] ^ measure_ff[31];
         end
         skb_pkg::STEP_PN: begin
            op_a   = mag62(om_ff);
            op_b   = MW'(pp_ff);
            op_neg = om_ff[63];
         end
         default: ;
      endcase
   end

   skb_mul u_mul (
      .clock  (clock),
      .reset  (reset),
      .start  (cmd.mul_start),
      .op_a   (op_a),
      .op_b   (op_b),
      .done   (mul_done),
      .result (mres)
   );

   skb_div u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_start),
      .num   ({hp_mag_ff[46:0], 16'b0}),
      .den   (den_ff),
      .done  (div_done),
      .quot  (quot)
   );

   always_comb begin
      sres     = apply_sign(mres, op_neg);
      xp_in    = 48'(predict_ff) * 48'(x_ff);
      sum_pu   = {2'b00, mres} + {33'b0, pnoise_ff};
      pp_in    = (|sum_pu[63:32]) ? '1 : sum_pu[31:0];
      sum_den  = {2'b00, mres} + {33'b0, snoise_ff};
      den_in   = (sum_den > {2'b00, skb_pkg::CAP}) ? skb_pkg::CAP : sum_den[MW-1:0];
      z_q      = {{(48-SW){item_ff.sample_value[SW-1]}}, item_ff.sample_value, 16'b0};
      innov_in = clamp_cap(z_q - sres);
      om_in    = clamp_cap(ONE_S - sres);
      xq       = clamp_cap(64'(xp_ff) + sres);
      xq_mag   = xq[63] ? 64'(-xq) : 64'(xq);
      est_full = xq[63] ? -$signed(xq_mag >> 16) : $signed(xq_mag >> 16);
      clip_in  = 1'b0;
      est_in   = est_full[SW-1:0];
      if (est_full > SMAX) begin
         est_in  = SMAX[SW-1:0];
         clip_in = 1'b1;
      end else if (est_full < SMIN) begin
         est_in  = SMIN[SW-1:0];
         clip_in = 1'b1;
      end
      if (sres < 0) begin
         pn_in = '0;
      end else if (|sres[63:32]) begin
         pn_in = '1;
      end else begin
         pn_in = sres[31:0];
      end
      km       = quot[MW] ? skb_pkg::CAP : quot[MW-1:0];
      den_zero = den_ff == '0;
   end

   always_ff @(posedge clock) begin
      if (cmd.capture_item) begin
         item_ff <= req_data;
         oor_ff  <= oor_in;
      end
      if (cmd.read_bank && !oor_ff) begin
         x_ff <= valid_ff[idx] ? est_mem[idx] : '0;
         p_ff <= valid_ff[idx] ? cov_mem[idx] : skb_pkg::ONE_Q;
      end
      if (cmd.calc_xp) begin
         xp_ff <= xp_in;
      end
      if (cmd.mul_capture) begin
         unique case (cmd.step)
            skb_pkg::STEP_AA:  aa_ff <= mres;
            skb_pkg::STEP_PU:  pp_ff <= pp_in;
            skb_pkg::STEP_HP: begin
               hp_mag_ff <= mres;
               hp_neg_ff <= op_neg;
            end
            skb_pkg::STEP_DEN: den_ff <= den_in;
            skb_pkg::STEP_HX:  innov_ff <= innov_in;
            skb_pkg::STEP_KI: begin
               est_ff  <= est_in;
               clip_ff <= clip_in;
            end
            skb_pkg::STEP_KH:  om_ff <= om_in;
            skb_pkg::STEP_PN:  pn_ff <= pn_in;
            default: ;
         endcase
      end
      if (cmd.div_capture) begin
         k_ff     <= den_zero ? '0 : apply_sign(km, hp_neg_ff);
         degen_ff <= den_zero;
      end
      if (cmd.write_bank) begin
         if (oor_ff) begin
            res_est_ff   <= '0;
            res_cov_ff   <= '0;
            res_degen_ff <= 1'b0;
            res_clip_ff  <= 1'b0;
         end else if (item_ff.cmd) begin
            est_mem[idx] <= item_ff.sample_value;
            cov_mem[idx] <= {1'b0, startcov_ff};
            res_est_ff   <= item_ff.sample_value;
            res_cov_ff   <= {1'b0, startcov_ff};
            res_degen_ff <= 1'b0;
            res_clip_ff  <= 1'b0;
         end else begin
            est_mem[idx] <= est_ff;
            cov_mem[idx] <= pn_ff;
            res_est_ff   <= est_ff;
            res_cov_ff   <= pn_ff;
            res_degen_ff <= degen_ff;
            res_clip_ff  <= clip_ff;
         end
      end
      if (cmd.load_rsp) begin
         rsp_ff.channel        <= item_ff.sensor_index;
         rsp_ff.estimate       <= res_est_ff;
         rsp_ff.covariance_out <= res_cov_ff;
         rsp_ff.degenerate     <= res_degen_ff;
         rsp_ff.clipped        <= res_clip_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (cmd.write_bank && !oor_ff) begin
         valid_ff[idx] <= 1'b1;
      end
   end

   assign sts.item_load = item_ff.cmd;
   assign sts.item_oor  = oor_ff;
   assign sts.mul_done  = mul_done;
   assign sts.div_done  = div_done;
   assign rsp_data      = rsp_ff;

endmodule

// ===== rtl/core/skb_ctrl.sv =====
module skb_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  skb_pkg::ctrl_sts_type  sts,
   output skb_pkg::ctrl_cmd_type  cmd
);

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_READ  = 4'd1;
   localparam logic [3:0] S_XP    = 4'd2;
   localparam logic [3:0] S_MUL   = 4'd3;
   localparam logic [3:0] S_MWAIT = 4'd4;
   localparam logic [3:0] S_DIV   = 4'd5;
   localparam logic [3:0] S_DWAIT = 4'd6;
   localparam logic [3:0] S_WRITE = 4'd7;
   localparam logic [3:0] S_DONE  = 4'd8;

   logic [3:0] state_ff, state_in;
   logic [2:0] step_ff, step_in;
   logic       rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in  = state_ff;
      step_in   = step_ff;
      req_ready = 1'b0;
      cmd       = '0;
      cmd.step  = step_ff;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture_item = 1'b1;
               state_in         = S_READ;
            end
         end
         S_READ: begin
            cmd.read_bank = 1'b1;
            state_in = (sts.item_oor || sts.item_load) ? S_WRITE : S_XP;
         end
         S_XP: begin
            cmd.calc_xp = 1'b1;
            step_in     = skb_pkg::STEP_AA;
            state_in    = S_MUL;
         end
         S_MUL: begin
            cmd.mul_start = 1'b1;
            state_in      = S_MWAIT;
         end
         S_MWAIT: begin
            if (sts.mul_done) begin
               cmd.mul_capture = 1'b1;
               if (step_ff == skb_pkg::STEP_DEN) begin
                  state_in = S_DIV;
               end else if (step_ff == skb_pkg::STEP_PN) begin
                  state_in = S_WRITE;
               end else begin
                  step_in  = step_ff + 3'd1;
                  state_in = S_MUL;
               end
            end
         end
         S_DIV: begin
            cmd.div_start = 1'b1;
            state_in      = S_DWAIT;
         end
         S_DWAIT: begin
            if (sts.div_done) begin
               cmd.div_capture = 1'b1;
               step_in         = skb_pkg::STEP_HX;
               state_in        = S_MUL;
            end
         end
         S_WRITE: begin
            cmd.write_bank = 1'b1;
            state_in       = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_rsp = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
      rsp_valid_in = cmd.load_rsp ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         step_ff      <= skb_pkg::STEP_AA;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== rtl/core/scalar_kalman_bank.sv =====
// Bank of NUM_SENSORS one-dimensional Kalman filters in Q16.16. A load item goes
// from acceptance through the read, write and done states to its result, as does
// an item whose index is out of range; a fuse item makes eight passes through the
// shared 31x31 partial-product multiplier plus a pass through the one-bit-per-cycle
// gain divider. One item is worked at a time; the next is accepted while the previous
// result still waits in the output register. csr_ready is always high; write
// registers only while the bank is idle.
module scalar_kalman_bank #(
   parameter int NUM_SENSORS = skb_pkg::NUM_SENSORS_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  skb_pkg::req_type                      req_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output skb_pkg::rsp_type                      rsp_data,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [skb_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [skb_pkg::CSR_DATA_WIDTH-1:0]    csr_wdata
);

   skb_pkg::ctrl_cmd_type cmd;
   skb_pkg::ctrl_sts_type sts;

   assign csr_ready = 1'b1;

   skb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   skb_datapath #(
      .NUM_SENSORS (NUM_SENSORS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_write (csr_valid),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_data  (rsp_data)
   );

`ifndef ASSERT_OFF
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("item accepted while busy");

   a_one_command: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.capture_item, cmd.read_bank, cmd.calc_xp, cmd.mul_start,
                cmd.mul_capture, cmd.div_start, cmd.div_capture, cmd.write_bank,
                cmd.load_rsp}))
      else $error("overlapping datapath commands");

   a_oor_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (32'(rsp_data.channel) >= NUM_SENSORS)) |->
      (rsp_data.estimate == '0 && rsp_data.covariance_out == '0 &&
       !rsp_data.degenerate && !rsp_data.clipped))
      else $error("out-of-range item gave nonzero result");
`endif

endmodule

// ===== sim/tb_scalar_kalman_bank.sv =====
`timescale 1ns / 100ps

module tb_scalar_kalman_bank;

   localparam logic CMD_FUSE = 1'b0;
   localparam logic CMD_LOAD = 1'b1;
   localparam int NSENS = skb_pkg::NUM_SENSORS_DEFAULT;
   localparam longint unsigned QCAP = 64'h3FFF_FFFF_FFFF_FFFF;
   localparam longint unsigned U32MAX = 64'hFFFF_FFFF;
   localparam longint CYCLE_LIMIT = 2_000_000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   skb_pkg::req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   skb_pkg::rsp_type rsp_data;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [skb_pkg::CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [skb_pkg::CSR_DATA_WIDTH-1:0] csr_wdata = '0;

   longint cycles = 0;
   int errors = 0;
   int stall_left = 0;
   bit quiet = 1'b0;
   skb_pkg::rsp_type pending_rsp[$];

   longint a_fac, h_fac;
   longint unsigned q_noise, r_noise, p_start;
   longint est_bank[NSENS];
   longint unsigned cov_bank[NSENS];

   scalar_kalman_bank i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("tb_scalar_kalman_bank NOT OK");
         $finish;
      end
   end

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (quiet || r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic longint unsigned magnitude(longint v);
      return v < 0 ? 64'd0 - longint'(v) : longint'(v);
   endfunction

   function automatic longint clamp_cap(longint v);
      if (v > longint'(QCAP)) return longint'(QCAP);
      if (v < -longint'(QCAP)) return -longint'(QCAP);
      return v;
   endfunction

   function automatic longint unsigned q_mul(longint unsigned a, longint unsigned b);
      longint unsigned p;
      if (a == 0 || b == 0) return 0;
      if (a > 64'hFFFF_FFFF_FFFF_FFFF / b) return QCAP;
      p = (a * b) >> 16;
      return p > QCAP ? QCAP : p;
   endfunction

   function automatic longint q_smul(longint a, longint b);
      longint m;
      m = longint'(q_mul(magnitude(a), magnitude(b)));
      return ((a < 0) != (b < 0)) ? -m : m;
   endfunction

   function automatic skb_pkg::rsp_type filter_update(skb_pkg::req_type r);
      skb_pkg::rsp_type o;
      int s;
      longint z, xp, pp, hp, k, innov, xq, est, om, pn;
      longint unsigned aa, pu, den, km;
      o = '0;
      s = r.sensor_index;
      z = r.sample_value;
      o.channel = r.sensor_index;
      if (r.cmd == CMD_LOAD) begin
         est_bank[s] = z;
         cov_bank[s] = p_start;
      end else begin
         xp = clamp_cap(a_fac * est_bank[s]);
         aa = q_mul(magnitude(a_fac), magnitude(a_fac));
         pu = q_mul(aa, cov_bank[s]) + q_noise;
         if (pu > U32MAX) pu = U32MAX;
         pp = longint'(pu);
         hp = q_smul(h_fac, pp);
         den = q_mul(magnitude(hp), magnitude(h_fac)) + r_noise;
         if (den > QCAP) den = QCAP;
         if (den == 0) begin
            k = 0;
            o.degenerate = 1'b1;
         end else begin
            km = (magnitude(hp) << 16) / den;
            if (km > QCAP) km = QCAP;
            k = hp < 0 ? -longint'(km) : longint'(km);
         end
         innov = clamp_cap(z * 65536 - q_smul(h_fac, xp));
         xq = clamp_cap(xp + q_smul(k, innov));
         est = xq / 65536;
         if (est > 32767) begin
            est = 32767;
            o.clipped = 1'b1;
         end
         if (est < -32768) begin
            est = -32768;
            o.clipped = 1'b1;
         end
         om = clamp_cap(longint'(65536) - q_smul(k, h_fac));
         pn = q_smul(om, pp);
         if (pn < 0) pn = 0;
         if (pn > longint'(U32MAX)) pn = longint'(U32MAX);
         est_bank[s] = est;
         cov_bank[s] = longint'(pn);
      end
      o.estimate = est_bank[s][15:0];
      o.covariance_out = cov_bank[s][31:0];
      return o;
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycles);
      errors++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            rsp_ready <= 1'b0;
         end else if ($urandom_range(0, 3) == 0) begin
            stall_left <= gap_len();
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      skb_pkg::rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_rsp.size() == 0) begin
            report_mismatch("unexpected item channel", rsp_data.channel, -1);
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_data.channel !== want.channel)
               report_mismatch("channel", rsp_data.channel, want.channel);
            if (rsp_data.estimate !== want.estimate)
               report_mismatch("estimate", rsp_data.estimate, want.estimate);
            if (rsp_data.covariance_out !== want.covariance_out)
               report_mismatch("covariance_out", rsp_data.covariance_out,
                               want.covariance_out);
            if (rsp_data.degenerate !== want.degenerate)
               report_mismatch("degenerate", rsp_data.degenerate, want.degenerate);
            if (rsp_data.clipped !== want.clipped)
               report_mismatch("clipped", rsp_data.clipped, want.clipped);
         end
      end
   end

   task automatic send_item(logic cmd, int sensor, int value);
      skb_pkg::req_type r;
      int gap;
      r.cmd = cmd;
      r.sensor_index = sensor[skb_pkg::INDEX_WIDTH-1:0];
      r.sample_value = value[15:0];
      gap = gap_len();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (!req_ready);
      pending_rsp.push_back(filter_update(r));
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (140) @(posedge clock);
   endtask

   task automatic write_csr(logic [skb_pkg::CSR_INDEX_WIDTH-1:0] idx, logic [31:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         skb_pkg::CSR_PREDICT_FACTOR:   a_fac = longint'($signed(data));
         skb_pkg::CSR_MEASURE_FACTOR:   h_fac = longint'($signed(data));
         skb_pkg::CSR_PROCESS_NOISE:    q_noise = data[30:0];
         skb_pkg::CSR_SENSOR_NOISE:     r_noise = data[30:0];
         skb_pkg::CSR_START_COVARIANCE: p_start = data[30:0];
         default: ;
      endcase
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_filter(logic [31:0] a, logic [31:0] h, logic [31:0] q,
                             logic [31:0] rn, logic [31:0] p0);
      drain();
      write_csr(skb_pkg::CSR_PREDICT_FACTOR, a);
      write_csr(skb_pkg::CSR_MEASURE_FACTOR, h);
      write_csr(skb_pkg::CSR_PROCESS_NOISE, q);
      write_csr(skb_pkg::CSR_SENSOR_NOISE, rn);
      write_csr(skb_pkg::CSR_START_COVARIANCE, p0);
   endtask

   function automatic logic [31:0] pick_word();
      case ($urandom_range(0, 7))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return 32'h0;
         3: return 32'hFFFF_FFFF;
         4, 5: return $urandom_range(0, 32'h0002_0000) - 32'h0001_0000;
         default: return $urandom;
      endcase
   endfunction

   function automatic int pick_sample();
      case ($urandom_range(0, 9))
         0: return -32768;
         1: return 32767;
         2: return 0;
         3, 4: return $urandom_range(0, 200) - 100;
         default: return $urandom_range(0, 65535) - 32768;
      endcase
   endfunction

   task automatic test_directed();
      send_item(CMD_FUSE, 0, 100);
      send_item(CMD_LOAD, 7, 32767);
      send_item(CMD_FUSE, 7, -32768);
      send_item(CMD_LOAD, 3, -32768);
      send_item(CMD_FUSE, 3, 32767);
      send_item(CMD_FUSE, 5, 0);
      set_filter(32'h7FFF_FFFF, 32'h0001_0000, 32'h7FFF_FFFF, 32'h0, 32'h7FFF_FFFF);
      send_item(CMD_LOAD, 1, 32767);
      send_item(CMD_FUSE, 1, -32768);
      send_item(CMD_LOAD, 2, -32768);
      send_item(CMD_FUSE, 2, 32767);
      set_filter(32'h8000_0000, 32'h0, 32'h0, 32'h0, 32'h0);
      send_item(CMD_FUSE, 4, 5);
      send_item(CMD_LOAD, 4, 1234);
      send_item(CMD_FUSE, 4, -5);
      set_filter(32'h0001_0000, 32'h8000_0000, 32'h1, 32'h1, 32'h0);
      send_item(CMD_LOAD, 6, 200);
      send_item(CMD_FUSE, 6, -200);
      send_item(CMD_FUSE, 6, 300);
      set_filter(32'h0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      send_item(CMD_FUSE, 0, 32767);
      send_item(CMD_FUSE, 7, -32768);
      drain();
      write_csr(3'd5, 32'hFFFF_FFFF);
      write_csr(3'd6, 32'h0);
      write_csr(3'd7, 32'h1234_5678);
      send_item(CMD_FUSE, 0, 1);
   endtask

   task automatic test_random_phases();
      for (int ph = 0; ph < 9; ph++) begin
         set_filter(pick_word(), pick_word(), pick_word(), pick_word(), pick_word());
         if ($urandom_range(0, 2) == 0) write_csr(3'($urandom_range(5, 7)), $urandom);
         quiet = (ph % 3 == 1);
         for (int n = 0; n < 155; n++) begin
            if ($urandom_range(0, 4) == 0)
               send_item(CMD_LOAD, $urandom_range(0, NSENS - 1), pick_sample());
            else
               send_item(CMD_FUSE, $urandom_range(0, NSENS - 1), pick_sample());
         end
         quiet = 1'b0;
      end
   endtask

   initial begin
      a_fac = 65536;
      h_fac = 65536;
      q_noise = 65536;
      r_noise = 65536;
      p_start = 65536;
      for (int i = 0; i < NSENS; i++) begin
         est_bank[i] = 0;
         cov_bank[i] = 65536;
      end
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random_phases();
      drain();
      if (pending_rsp.size() != 0)
         report_mismatch("items left over", pending_rsp.size(), 0);
      if (errors == 0) begin
         $display("tb_scalar_kalman_bank OK");
      end else begin
         $display("tb_scalar_kalman_bank NOT OK");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/core/skb_pkg.sv
rtl/core/skb_mul.sv
rtl/core/skb_div.sv
rtl/core/skb_datapath.sv
rtl/core/skb_ctrl.sv
rtl/core/scalar_kalman_bank.sv
sim/tb_scalar_kalman_bank.sv
